### hw/rtl/sbi_pkg.sv
// Shared widths, types and constants for the segment to box intersection pipeline.
`timescale 1ns / 1ps
`default_nettype none

package sbi_pkg;

   localparam int unsigned COORD_WIDTH     = 16;
   localparam int unsigned FRAC_BITS       = 20;
   localparam int unsigned DIFF_W          = COORD_WIDTH + 1;
   localparam int unsigned MAG_W           = COORD_WIDTH;
   localparam int unsigned QUOT_W          = FRAC_BITS + 1;
   localparam int unsigned T_W             = FRAC_BITS + 2;
   localparam int unsigned STEPS_PER_STAGE = 3;
   localparam int unsigned DIV_STAGES      =
      (QUOT_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int unsigned PIPE_W          = DIV_STAGES + 1;
   localparam int unsigned CLIP_STAGES     = 3;
   localparam int unsigned LATENCY         = 1 + DIV_STAGES + CLIP_STAGES;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic        [MAG_W-1:0]       mag_type;
   typedef logic        [MAG_W:0]         rem_type;
   typedef logic        [QUOT_W-1:0]      quot_type;
   typedef logic signed [T_W-1:0]         t_type;

   typedef struct packed {
      logic neg;
      logic sat;
   } lane_tag_type;

   typedef struct packed {
      lane_tag_type tag;
      quot_type     quot;
   } lane_res_type;

   typedef struct packed {
      logic moving;
      logic in_slab;
   } axis_type;

   localparam t_type T_ZERO  = '0;
   localparam t_type T_UNDER = '1;
   localparam t_type T_ONE   = t_type'(1) << FRAC_BITS;
   localparam t_type T_OVER  = T_ONE + t_type'(1);

endpackage

`default_nettype wire

### hw/rtl/segment_box_intersect.sv
// Top level of the segment to axis-aligned box intersection pipeline.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start high, busy low   req_start_x/z, req_end_x/z, req_box_*
//   response  out        rsp_valid, one cycle   rsp_hit
//
// One item is accepted per cycle and its result passes through one input stage,
// seven divider stages of three quotient bits each and three clipping stages.
// The four slab divisions run side by side in their own divider pipelines.
// Synchronous reset empties the pipeline; busy is high only while reset is held.
// The receiver cannot stall, so the pipeline never holds an item back.
`timescale 1ns / 1ps
`default_nettype none

module segment_box_intersect (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sbi_pkg::coord_type req_start_x,
   input  sbi_pkg::coord_type req_start_z,
   input  sbi_pkg::coord_type req_end_x,
   input  sbi_pkg::coord_type req_end_z,
   input  sbi_pkg::coord_type req_box_min_x,
   input  sbi_pkg::coord_type req_box_max_x,
   input  sbi_pkg::coord_type req_box_min_z,
   input  sbi_pkg::coord_type req_box_max_z,
   output logic               rsp_valid,
   output logic               rsp_hit
);
   import sbi_pkg::*;

   logic              accept;
   logic [PIPE_W-1:0] vld_in;
   logic [PIPE_W-1:0] vld_ff;

   axis_type     axis_x, axis_z;
   mag_type      num_x_min, num_x_max, num_z_min, num_z_max;
   lane_tag_type tag_x_min, tag_x_max, tag_z_min, tag_z_max;
   mag_type      den_x, den_z;
   lane_res_type res_x_min, res_x_max, res_z_min, res_z_max;

   axis_type     axis_x_ff [DIV_STAGES];
   axis_type     axis_z_ff [DIV_STAGES];

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[PIPE_W-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_x_ff[0] <= axis_x;
      axis_z_ff[0] <= axis_z;
      for (int i = 1; i < DIV_STAGES; i++) begin
         axis_x_ff[i] <= axis_x_ff[i-1];
         axis_z_ff[i] <= axis_z_ff[i-1];
      end
   end

   sbi_prep u_prep_x (
      .clock   (clock),
      .start_c (req_start_x),
      .end_c   (req_end_x),
      .box_min (req_box_min_x),
      .box_max (req_box_max_x),
      .axis    (axis_x),
      .num_min (num_x_min),
      .num_max (num_x_max),
      .tag_min (tag_x_min),
      .tag_max (tag_x_max),
      .den     (den_x)
   );

   sbi_prep u_prep_z (
      .clock   (clock),
      .start_c (req_start_z),
      .end_c   (req_end_z),
      .box_min (req_box_min_z),
      .box_max (req_box_max_z),
      .axis    (axis_z),
      .num_min (num_z_min),
      .num_max (num_z_max),
      .tag_min (tag_z_min),
      .tag_max (tag_z_max),
      .den     (den_z)
   );

   sbi_div u_div_x_min (
      .clock  (clock),
      .num    (num_x_min),
      .den    (den_x),
      .tag_in (tag_x_min),
      .res    (res_x_min)
   );

   sbi_div u_div_x_max (
      .clock  (clock),
      .num    (num_x_max),
      .den    (den_x),
      .tag_in (tag_x_max),
      .res    (res_x_max)
   );

   sbi_div u_div_z_min (
      .clock  (clock),
      .num    (num_z_min),
      .den    (den_z),
      .tag_in (tag_z_min),
      .res    (res_z_min)
   );

   sbi_div u_div_z_max (
      .clock  (clock),
      .num    (num_z_max),
      .den    (den_z),
      .tag_in (tag_z_max),
      .res    (res_z_max)
   );

   sbi_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[PIPE_W-1]),
      .axis_x    (axis_x_ff[DIV_STAGES-1]),
      .axis_z    (axis_z_ff[DIV_STAGES-1]),
      .res_x_min (res_x_min),
      .res_x_max (res_x_max),
      .res_z_min (res_z_min),
      .res_z_max (res_z_max),
      .rsp_valid (rsp_valid),
      .rsp_hit   (rsp_hit)
   );

endmodule

`default_nettype wire

### hw/rtl/sbi_prep.sv
// Input stage for one axis: offsets, magnitudes, signs and the zero-extent slab test.
`timescale 1ns / 1ps
`default_nettype none

module sbi_prep (
   input  logic                 clock,
   input  sbi_pkg::coord_type   start_c,
   input  sbi_pkg::coord_type   end_c,
   input  sbi_pkg::coord_type   box_min,
   input  sbi_pkg::coord_type   box_max,
   output sbi_pkg::axis_type    axis,
   output sbi_pkg::mag_type     num_min,
   output sbi_pkg::mag_type     num_max,
   output sbi_pkg::lane_tag_type tag_min,
   output sbi_pkg::lane_tag_type tag_max,
   output sbi_pkg::mag_type     den
);
   import sbi_pkg::*;

   function automatic mag_type mag_of(input diff_type v);
      diff_type neg_v;
      neg_v = -v;
      return v[DIFF_W-1] ? neg_v[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

   diff_type     delta;
   diff_type     off_min;
   diff_type     off_max;
   mag_type      mag_delta;
   mag_type      mag_min;
   mag_type      mag_max;

   axis_type     axis_in;
   lane_tag_type tag_min_in;
   lane_tag_type tag_max_in;
   mag_type      den_in;

   axis_type     axis_ff;
   mag_type      num_min_ff;
   mag_type      num_max_ff;
   lane_tag_type tag_min_ff;
   lane_tag_type tag_max_ff;
   mag_type      den_ff;

   always_comb begin
      delta     = diff_type'(end_c) - diff_type'(start_c);
      off_min   = diff_type'(box_min) - diff_type'(start_c);
      off_max   = diff_type'(box_max) - diff_type'(start_c);
      mag_delta = mag_of(delta);
      mag_min   = mag_of(off_min);
      mag_max   = mag_of(off_max);

      axis_in.moving  = (delta != '0);
      axis_in.in_slab = (start_c >= box_min) && (start_c <= box_max);

      tag_min_in.neg = off_min[DIFF_W-1] ^ delta[DIFF_W-1];
      tag_min_in.sat = (mag_min > mag_delta);
      tag_max_in.neg = off_max[DIFF_W-1] ^ delta[DIFF_W-1];
      tag_max_in.sat = (mag_max > mag_delta);

      den_in = axis_in.moving ? mag_delta : mag_type'(1);
   end

   always_ff @(posedge clock) begin
      axis_ff    <= axis_in;
      num_min_ff <= mag_min;
      num_max_ff <= mag_max;
      tag_min_ff <= tag_min_in;
      tag_max_ff <= tag_max_in;
      den_ff     <= den_in;
   end

   assign axis    = axis_ff;
   assign num_min = num_min_ff;
   assign num_max = num_max_ff;
   assign tag_min = tag_min_ff;
   assign tag_max = tag_max_ff;
   assign den     = den_ff;

endmodule

`default_nettype wire

### hw/rtl/sbi_div.sv
// Pipelined restoring divider that forms the fixed-point ratio of two magnitudes.
`timescale 1ns / 1ps
`default_nettype none

module sbi_div (
   input  logic                  clock,
   input  sbi_pkg::mag_type      num,
   input  sbi_pkg::mag_type      den,
   input  sbi_pkg::lane_tag_type tag_in,
   output sbi_pkg::lane_res_type res
);
   import sbi_pkg::*;

   rem_type      rem_in  [DIV_STAGES];
   quot_type     quot_in [DIV_STAGES];
   rem_type      rem_ff  [DIV_STAGES-1];
   mag_type      den_ff  [DIV_STAGES-1];
   quot_type     quot_ff [DIV_STAGES];
   lane_tag_type tag_ff  [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      rem_type      rem_src;
      mag_type      den_src;
      quot_type     quot_src;
      lane_tag_type tag_src;

      if (s == 0) begin : g_first
         assign rem_src  = {1'b0, num};
         assign den_src  = den;
         assign quot_src = '0;
         assign tag_src  = tag_in;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign quot_src = quot_ff[s-1];
         assign tag_src  = tag_ff[s-1];
      end

      always_comb begin
         rem_type  r;
         rem_type  diff;
         quot_type q;
         logic     qbit;
         r    = rem_src;
         q    = quot_src;
         diff = '0;
         qbit = 1'b0;
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            if (s * STEPS_PER_STAGE + k < QUOT_W) begin
               qbit = (r >= {1'b0, den_src});
               diff = r - {1'b0, den_src};
               q    = {q[QUOT_W-2:0], qbit};
               r    = qbit ? {diff[MAG_W-1:0], 1'b0} : {r[MAG_W-1:0], 1'b0};
            end
         end
         rem_in[s]  = r;
         quot_in[s] = q;
      end

      always_ff @(posedge clock) begin
         quot_ff[s] <= quot_in[s];
         tag_ff[s]  <= tag_src;
      end

      if (s < DIV_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_src;
         end
      end
   end

   assign res.tag  = tag_ff[DIV_STAGES-1];
   assign res.quot = quot_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

### hw/rtl/sbi_clip.sv
// Clamps the slab parameters, intersects the intervals and registers the hit flag.
`timescale 1ns / 1ps
`default_nettype none

module sbi_clip (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sbi_pkg::axis_type     axis_x,
   input  sbi_pkg::axis_type     axis_z,
   input  sbi_pkg::lane_res_type res_x_min,
   input  sbi_pkg::lane_res_type res_x_max,
   input  sbi_pkg::lane_res_type res_z_min,
   input  sbi_pkg::lane_res_type res_z_max,
   output logic                  rsp_valid,
   output logic                  rsp_hit
);
   import sbi_pkg::*;

   function automatic t_type to_t(input lane_res_type r);
      t_type t;
      if (r.tag.neg) begin
         t = (r.tag.sat || (r.quot != '0)) ? T_UNDER : T_ZERO;
      end else if (r.tag.sat) begin
         t = T_OVER;
      end else begin
         t = t_type'({1'b0, r.quot});
      end
      return t;
   endfunction

   t_type ta_x, tb_x, ta_z, tb_z;
   t_type lo_x_in, hi_x_in, lo_z_in, hi_z_in;
   logic  miss_a_in;
   t_type lo_b_in, hi_b_in;
   logic  hit_in;

   logic  vld_a_ff, vld_b_ff, rsp_valid_ff;
   t_type lo_x_ff, hi_x_ff, lo_z_ff, hi_z_ff;
   logic  miss_a_ff, miss_b_ff;
   t_type lo_b_ff, hi_b_ff;
   logic  rsp_hit_ff;

   always_comb begin
      ta_x = axis_x.moving ? to_t(res_x_min) : T_UNDER;
      tb_x = axis_x.moving ? to_t(res_x_max) : T_OVER;
      ta_z = axis_z.moving ? to_t(res_z_min) : T_UNDER;
      tb_z = axis_z.moving ? to_t(res_z_max) : T_OVER;

      lo_x_in = (ta_x > tb_x) ? tb_x : ta_x;
      hi_x_in = (ta_x > tb_x) ? ta_x : tb_x;
      lo_z_in = (ta_z > tb_z) ? tb_z : ta_z;
      hi_z_in = (ta_z > tb_z) ? ta_z : tb_z;

      miss_a_in = (!axis_x.moving && !axis_x.in_slab) ||
                  (!axis_z.moving && !axis_z.in_slab);
   end

   always_comb begin
      lo_b_in = T_ZERO;
      if (lo_x_ff > lo_b_in) lo_b_in = lo_x_ff;
      if (lo_z_ff > lo_b_in) lo_b_in = lo_z_ff;
      hi_b_in = T_ONE;
      if (hi_x_ff < hi_b_in) hi_b_in = hi_x_ff;
      if (hi_z_ff < hi_b_in) hi_b_in = hi_z_ff;
   end

   assign hit_in = !miss_b_ff && (lo_b_ff <= hi_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff     <= 1'b0;
         vld_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_a_ff     <= in_valid;
         vld_b_ff     <= vld_a_ff;
         rsp_valid_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_x_ff    <= lo_x_in;
      hi_x_ff    <= hi_x_in;
      lo_z_ff    <= lo_z_in;
      hi_z_ff    <= hi_z_in;
      miss_a_ff  <= miss_a_in;
      lo_b_ff    <= lo_b_in;
      hi_b_ff    <= hi_b_in;
      miss_b_ff  <= miss_a_ff;
      rsp_hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

### hw/rtl/sbi_checker.sv
// Port-level checker for the intersection pipeline and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sbi_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input sbi_pkg::coord_type req_start_x,
   input sbi_pkg::coord_type req_start_z,
   input sbi_pkg::coord_type req_end_x,
   input sbi_pkg::coord_type req_end_z,
   input sbi_pkg::coord_type req_box_min_x,
   input sbi_pkg::coord_type req_box_max_x,
   input sbi_pkg::coord_type req_box_min_z,
   input sbi_pkg::coord_type req_box_max_z,
   input logic               rsp_valid,
   input logic               rsp_hit
);
   import sbi_pkg::*;

   logic acc;
   logic start_inside;
   logic end_inside;
   logic left_of_box;

   assign acc = start && !busy;

   assign start_inside = (req_start_x >= req_box_min_x) && (req_start_x <= req_box_max_x) &&
                         (req_start_z >= req_box_min_z) && (req_start_z <= req_box_max_z);

   assign end_inside = (req_end_x >= req_box_min_x) && (req_end_x <= req_box_max_x) &&
                       (req_end_z >= req_box_min_z) && (req_end_z <= req_box_max_z);

   assign left_of_box = (req_box_min_x <= req_box_max_x) &&
                        (req_start_x < req_box_min_x) && (req_end_x < req_box_min_x);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe seen right after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc, LATENCY))
      else $error("result strobe without an item accepted at the pipeline latency");

   a_start_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(acc && start_inside, LATENCY) |-> rsp_hit)
      else $error("segment starting inside the box reported as a miss");

   a_end_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(acc && end_inside, LATENCY) |-> rsp_hit)
      else $error("segment ending inside the box reported as a miss");

   a_left_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(acc && left_of_box, LATENCY) |-> !rsp_hit)
      else $error("segment wholly left of the box reported as a hit");

endmodule

bind segment_box_intersect sbi_checker u_checker (.*);

`default_nettype wire

### bench/tb_segment_box_intersect.sv
// Self-checking testbench for the segment to axis-aligned box intersection pipeline.
`timescale 1ns / 1ps

module tb_segment_box_intersect;
   import sbi_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      coord_type sx;
      coord_type sz;
      coord_type ex;
      coord_type ez;
      coord_type min_x;
      coord_type max_x;
      coord_type min_z;
      coord_type max_z;
   } seg_box_item;

   typedef struct {
      seg_box_item item;
      bit          hit;
   } pending_hit;

   class hit_scoreboard;
      pending_hit pending_hits[$];
      int         fail_count;

      function bit clip_slab(input longint p, input longint q, input longint bmin,
                             input longint bmax, inout longint t_lo, inout longint t_hi);
         longint d;
         longint t_in;
         longint t_out;
         longint t_swap;
         d = q - p;
         if (d == 0) begin
            return !(p < bmin || p > bmax);
         end
         t_in  = ((bmin - p) * (longint'(1) << FRAC_BITS)) / d;
         t_out = ((bmax - p) * (longint'(1) << FRAC_BITS)) / d;
         if (t_in > t_out) begin
            t_swap = t_in;
            t_in   = t_out;
            t_out  = t_swap;
         end
         if (t_in > t_lo) t_lo = t_in;
         if (t_out < t_hi) t_hi = t_out;
         return t_lo <= t_hi;
      endfunction

      function bit segment_touches_box(seg_box_item it);
         longint t_lo;
         longint t_hi;
         bit     touches;
         t_lo = 0;
         t_hi = longint'(1) << FRAC_BITS;
         touches = clip_slab(it.sx, it.ex, it.min_x, it.max_x, t_lo, t_hi);
         if (touches) touches = clip_slab(it.sz, it.ez, it.min_z, it.max_z, t_lo, t_hi);
         return touches;
      endfunction

      function void note_item(seg_box_item it);
         pending_hit p;
         p.item = it;
         p.hit  = segment_touches_box(it);
         pending_hits.push_back(p);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      task check_hit(logic got);
         pending_hit p;
         if (pending_hits.size() == 0) begin
            report($sformatf("hit %b arrived with no item pending", got));
         end else begin
            p = pending_hits.pop_front();
            if (got !== p.hit) begin
               report($sformatf("(%0d,%0d)->(%0d,%0d) x[%0d,%0d] z[%0d,%0d]: hit %b, expected %b",
                  p.item.sx, p.item.sz, p.item.ex, p.item.ez, p.item.min_x, p.item.max_x,
                  p.item.min_z, p.item.max_z, got, p.hit));
            end
         end
      endtask

      function int pending();
         return pending_hits.size();
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_start_x = '0;
   coord_type req_start_z = '0;
   coord_type req_end_x = '0;
   coord_type req_end_z = '0;
   coord_type req_box_min_x = '0;
   coord_type req_box_max_x = '0;
   coord_type req_box_min_z = '0;
   coord_type req_box_max_z = '0;
   logic      rsp_valid;
   logic      rsp_hit;

   hit_scoreboard sb = new();
   int            stall_cycles = 0;

   segment_box_intersect i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_start_x   (req_start_x),
      .req_start_z   (req_start_z),
      .req_end_x     (req_end_x),
      .req_end_z     (req_end_z),
      .req_box_min_x (req_box_min_x),
      .req_box_max_x (req_box_max_x),
      .req_box_min_z (req_box_min_z),
      .req_box_max_z (req_box_max_z),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit)
   );

   always #10 clock = ~clock;

   // Results are checked before the item accepted at the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            sb.check_hit(rsp_hit);
         end
         if (start && busy === 1'b0) begin
            sb.note_item('{req_start_x, req_start_z, req_end_x, req_end_z,
                           req_box_min_x, req_box_max_x, req_box_min_z, req_box_max_z});
         end
      end
   end

   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_segment_box_intersect: FAIL");
         $finish;
      end
   end

   function automatic coord_type clamp_coord(int v);
      if (v > 32767) return coord_type'(32767);
      if (v < -32768) return coord_type'(-32768);
      return coord_type'(v);
   endfunction

   function automatic int rand_offset(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic coord_type rand_extreme();
      case ($urandom_range(4))
         0: return coord_type'(-32768);
         1: return coord_type'(32767);
         2: return coord_type'(0);
         3: return coord_type'(-1);
         default: return coord_type'($urandom_range(65535));
      endcase
   endfunction

   function automatic seg_box_item make_item(int sx, int sz, int ex, int ez,
                                             int min_x, int max_x, int min_z, int max_z);
      seg_box_item it;
      it.sx    = clamp_coord(sx);
      it.sz    = clamp_coord(sz);
      it.ex    = clamp_coord(ex);
      it.ez    = clamp_coord(ez);
      it.min_x = clamp_coord(min_x);
      it.max_x = clamp_coord(max_x);
      it.min_z = clamp_coord(min_z);
      it.max_z = clamp_coord(max_z);
      return it;
   endfunction

   function automatic seg_box_item random_item();
      seg_box_item it;
      coord_type   tmp;
      int          cx;
      int          cz;
      int          hx;
      int          hz;
      int          reach;
      int          sel;
      sel = $urandom_range(9);
      cx  = int'($urandom_range(65535)) - 32768;
      cz  = int'($urandom_range(65535)) - 32768;
      hx  = ($urandom_range(7) == 0) ? $urandom_range(8000) : $urandom_range(200);
      hz  = ($urandom_range(7) == 0) ? $urandom_range(8000) : $urandom_range(200);
      reach = 3 * ((hx > hz) ? hx : hz) + 4;
      it = make_item(cx + rand_offset(reach), cz + rand_offset(reach),
                     cx + rand_offset(reach), cz + rand_offset(reach),
                     cx - hx, cx + hx, cz - hz, cz + hz);
      case (sel)
         0: begin
            it = make_item(int'(coord_type'($urandom())), int'(coord_type'($urandom())),
                           int'(coord_type'($urandom())), int'(coord_type'($urandom())),
                           int'(coord_type'($urandom())), int'(coord_type'($urandom())),
                           int'(coord_type'($urandom())), int'(coord_type'($urandom())));
         end
         6: begin
            if ($urandom_range(1)) it.ex = it.sx;
            else it.ez = it.sz;
         end
         7: begin
            it.ex = it.sx;
            it.ez = it.sz;
         end
         8: begin
            it.sx = $urandom_range(1) ? it.min_x : it.max_x;
            it.sz = $urandom_range(1) ? it.min_z : it.max_z;
            if ($urandom_range(1)) it.ex = $urandom_range(1) ? it.min_x : it.max_x;
            if ($urandom_range(1)) it.ez = $urandom_range(1) ? it.min_z : it.max_z;
         end
         9: begin
            it.sx    = rand_extreme();
            it.sz    = rand_extreme();
            it.ex    = rand_extreme();
            it.ez    = rand_extreme();
            it.min_x = rand_extreme();
            it.max_x = rand_extreme();
            it.min_z = rand_extreme();
            it.max_z = rand_extreme();
         end
         default: ;
      endcase
      if ($urandom_range(15) == 0) begin
         tmp      = it.min_x;
         it.min_x = it.max_x;
         it.max_x = tmp;
      end
      if ($urandom_range(15) == 0) begin
         tmp      = it.min_z;
         it.min_z = it.max_z;
         it.max_z = tmp;
      end
      return it;
   endfunction

   // Start stays high from one item to the next unless the sender idles in between.
   task automatic send_item(seg_box_item it, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_start_x   <= it.sx;
      req_start_z   <= it.sz;
      req_end_x     <= it.ex;
      req_end_z     <= it.ez;
      req_box_min_x <= it.min_x;
      req_box_max_x <= it.max_x;
      req_box_min_z <= it.min_z;
      req_box_max_z <= it.max_z;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      seg_box_item directed[$];
      int          idle_pct[3];
      idle_pct = '{30, 85, 0};
      directed = '{
         make_item(0, 0, 0, 0, 0, 0, 0, 0),
         make_item(5, 5, 5, 5, 0, 10, 0, 10),
         make_item(10, 10, 10, 10, 0, 10, 0, 10),
         make_item(11, 5, 11, 5, 0, 10, 0, 10),
         make_item(5, -1, 5, -1, 0, 10, 0, 10),
         make_item(20, -50, 20, 50, 0, 10, 0, 10),
         make_item(-50, 5, 50, 5, 0, 10, 0, 10),
         make_item(-32768, -32768, 32767, 32767, -1, 1, -1, 1),
         make_item(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767),
         make_item(-10, 5, 0, 5, 0, 10, 0, 10),
         make_item(-10, 5, -1, 5, 0, 10, 0, 10),
         make_item(-5, 5, 5, -5, 0, 10, 0, 10),
         make_item(-5, 6, 6, -5, 1, 10, 1, 10),
         make_item(5, 5, 5, 5, 10, 0, 0, 10),
         make_item(-20, 5, 20, 5, 10, -10, 0, 10),
         make_item(5, 5, 5, 5, 10, 0, 10, 0),
         make_item(-32768, 32767, 32767, -32768, -32768, 32767, -32768, 32767),
         make_item(32767, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
         make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
         make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
         make_item(0, 0, 3, 3, 1, 1, 2, 2),
         make_item(0, 0, 3, 1, 1, 1, 0, 0),
         make_item(20, 5, 30, 5, 0, 10, 0, 10),
         make_item(32767, -32768, -32768, 32767, 0, 0, 0, 0),
         make_item(-32768, 0, 32767, 1, -1, -1, 0, 0)
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_item(directed[i], 0);
      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < 150; n++) begin
            if (n == 75) drain_results();
            send_item(random_item(), idle_pct[phase]);
         end
      end
      drain_results();
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));
      end
      if (sb.fail_count == 0) begin
         $display("tb_segment_box_intersect: PASS");
      end else begin
         $display("tb_segment_box_intersect: FAIL");
      end
      $finish;
   end

endmodule
